FILE: sv/lzwve_pkg.sv
package lzwve_pkg;

    localparam int CODE_W  = 12;
    localparam int WIDTH_W = 4;
    localparam int LINK_W  = 13;
    localparam int SYM_W   = 8;
    localparam int COUNT_W = 13;
    localparam int PIX_W   = 4;

    // Bit 12 of a link, head or prefix marks "none".
    localparam logic [LINK_W-1:0]  NO_LINK   = 13'h1000;
    localparam logic [WIDTH_W-1:0] MAX_WIDTH = 4'd12;
    localparam logic [PIX_W-1:0]   PIX_MIN   = 4'd2;
    localparam logic [PIX_W-1:0]   PIX_MAX   = 4'd8;
    localparam logic [PIX_W-1:0]   PIX_RESET = 4'd8;

    typedef struct packed {
        logic [CODE_W-1:0] prefix;
        logic [SYM_W-1:0]  symbol;
        logic [LINK_W-1:0] link;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_START_CLR,
        ST_PROC,
        ST_HEAD,
        ST_WALK,
        ST_CMP,
        ST_MISS_EMIT,
        ST_INSERT,
        ST_FULL_CLR,
        ST_LAST,
        ST_FLUSH,
        ST_END,
        ST_DONE
    } state_t;

endpackage

FILE: sv/lzwve_dict.sv
module lzwve_dict #(
    parameter int DICT_ENTRIES = 4096,
    parameter int HASH_BUCKETS = 4096
) (
    input  logic                                aclk,
    input  logic                                head_we,
    input  logic [$clog2(HASH_BUCKETS)-1:0]     head_waddr,
    input  logic [lzwve_pkg::LINK_W-1:0]        head_wdata,
    input  logic [$clog2(HASH_BUCKETS)-1:0]     head_raddr,
    output logic [lzwve_pkg::LINK_W-1:0]        head_rdata,
    input  logic                                ent_we,
    input  logic [$clog2(DICT_ENTRIES)-1:0]     ent_waddr,
    input  lzwve_pkg::entry_t                   ent_wdata,
    input  logic [$clog2(DICT_ENTRIES)-1:0]     ent_raddr,
    output lzwve_pkg::entry_t                   ent_rdata
);
    import lzwve_pkg::*;

    // Bucket heads and the entry store, each one write and one registered read port.
    logic [LINK_W-1:0] head_mem [HASH_BUCKETS];
    entry_t            ent_mem  [DICT_ENTRIES];

    always_ff @(posedge aclk) begin
        if (head_we) begin
            head_mem[head_waddr] <= head_wdata;
        end
        head_rdata <= head_mem[head_raddr];
    end

    always_ff @(posedge aclk) begin
        if (ent_we) begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        ent_rdata <= ent_mem[ent_raddr];
    end

endmodule

FILE: sv/lzw_variable_width_encoder_core.sv
// Channel  | Direction | Transaction carries
// ---------+-----------+-------------------------------------------------------
// s_       | in        | tdata[7:0] data_byte, tlast last_byte
// m_       | out       | tdata[11:0] code, tdata[15:12] code_width, tlast last_code
// cfg_     | in        | cfg_data[3:0] pixel_bits, no address
//
// An item is accepted in ST_IDLE and its prefix is examined in ST_PROC. With no prefix
// yet it goes straight to the finishing states ST_LAST and ST_DONE. Otherwise ST_HEAD
// reads its bucket head, each chain entry visited passes through ST_WALK and ST_CMP,
// and a miss sees the chain end in ST_WALK, emits the prefix in ST_MISS_EMIT and
// inserts the new pair in ST_INSERT; ST_LAST and ST_DONE then finish the item. A
// flushed prefix and the end code add a state each, ST_FLUSH and ST_END.
// The first item of each stream, and an item that finds the dictionary full, adds a
// clearing pass over every bucket of the bucket head memory; the same pass
// covers the state after reset, since the first item always opens a stream.
// Reset is synchronous and active low. A stall on m_ holds the sequencer once a
// finished code is waiting and a new one is ready to be emitted, and holds the last
// cycle of an item until its final code can leave.
module lzw_variable_width_encoder_core #(
    parameter int DICT_ENTRIES = 4096,
    parameter int HASH_BUCKETS = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [11:0] code, [15:12] code_width
    output logic        m_tlast,   // last_code
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [lzwve_pkg::PIX_W-1:0] cfg_data
);
    import lzwve_pkg::*;

    localparam int HW = $clog2(HASH_BUCKETS);
    localparam int EW = $clog2(DICT_ENTRIES);
    localparam logic [COUNT_W-1:0] DICT_LIMIT = COUNT_W'(DICT_ENTRIES);
    localparam logic [HW:0]        BUCKETS    = (HW+1)'(HASH_BUCKETS);
    localparam logic [HW-1:0]      SWEEP_LAST = HW'(HASH_BUCKETS - 1);

    state_t              state_reg, state_next;
    logic [PIX_W-1:0]    pixel_reg, pixel_next;
    logic                open_reg, open_next;
    logic [LINK_W-1:0]   prefix_reg, prefix_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [WIDTH_W-1:0]  width_reg, width_next;
    logic [SYM_W-1:0]    sym_reg, sym_next;
    logic                last_reg, last_next;
    logic [HW-1:0]       hash_reg, hash_next;
    logic [LINK_W-1:0]   idx_reg, idx_next;
    logic [LINK_W-1:0]   headsave_reg, headsave_next;
    logic [HW-1:0]       sweep_reg, sweep_next;
    logic                sweepfull_reg, sweepfull_next;
    logic [CODE_W-1:0]   pend_code_reg, pend_code_next;
    logic [WIDTH_W-1:0]  pend_width_reg, pend_width_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [CODE_W-1:0]   out_code_reg, out_code_next;
    logic [WIDTH_W-1:0]  out_width_reg, out_width_next;
    logic                out_last_reg, out_last_next;
    logic                out_valid_reg, out_valid_next;

    logic [PIX_W-1:0]    eff_bits;
    logic [CODE_W-1:0]   clear_code;
    logic [SYM_W-1:0]    sym_mask;
    logic [HW-1:0]       hash_fold;
    logic [HW:0]         hash_wide;
    logic [HW-1:0]       hash_now;
    logic                out_free;
    logic                can_emit;
    logic                emit_en;
    logic [CODE_W-1:0]   emit_code;
    logic [WIDTH_W-1:0]  emit_width;
    logic                grow;

    logic                head_we;
    logic [HW-1:0]       head_waddr;
    logic [LINK_W-1:0]   head_wdata;
    logic [LINK_W-1:0]   head_rdata;
    logic                ent_we;
    entry_t              ent_wdata;
    entry_t              ent_rdata;

    lzwve_dict #(
        .DICT_ENTRIES (DICT_ENTRIES),
        .HASH_BUCKETS (HASH_BUCKETS)
    ) u_dict (
        .aclk       (aclk),
        .head_we    (head_we),
        .head_waddr (head_waddr),
        .head_wdata (head_wdata),
        .head_raddr (hash_now),
        .head_rdata (head_rdata),
        .ent_we     (ent_we),
        .ent_waddr  (count_reg[EW-1:0]),
        .ent_wdata  (ent_wdata),
        .ent_raddr  (idx_reg[EW-1:0]),
        .ent_rdata  (ent_rdata)
    );

    // Symbol width is clamped to the supported range of two to eight bits.
    always_comb begin
        priority if (pixel_reg < PIX_MIN) begin
            eff_bits = PIX_MIN;
        end else if (pixel_reg > PIX_MAX) begin
            eff_bits = PIX_MAX;
        end else begin
            eff_bits = pixel_reg;
        end
    end

    assign clear_code = CODE_W'(1) << eff_bits;
    assign sym_mask   = SYM_W'((9'(1) << eff_bits) - 9'(1));

    // The hash only has to spread pairs over buckets: the prefix and symbol are
    // XOR-folded into the bucket index width, then brought below the bucket count
    // with a single subtraction, as the folded value stays below twice that count.
    always_comb begin
        hash_fold = '0;
        for (int i = 0; i < CODE_W + SYM_W; i++) begin
            if (i < SYM_W) begin
                hash_fold[i % HW] = hash_fold[i % HW] ^ sym_reg[i];
            end else begin
                hash_fold[i % HW] = hash_fold[i % HW] ^ prefix_reg[i - SYM_W];
            end
        end
        hash_wide = {1'b0, hash_fold};
        if (hash_wide >= BUCKETS) begin
            hash_wide = hash_wide - BUCKETS;
        end
        hash_now = hash_wide[HW-1:0];
    end

    // The code width grows just before a code leaves, once the newest dictionary code
    // no longer fits the current width.
    assign grow       = (count_reg > (COUNT_W'(1) << width_reg)) && (width_reg < MAX_WIDTH);
    assign emit_width = grow ? width_reg + WIDTH_W'(1) : width_reg;

    // A code waits in the pending slot until the next one arrives or the item ends,
    // so that the final code of each item can be flagged with tlast.
    assign out_free = !out_valid_reg || m_tready;
    assign can_emit = !pend_valid_reg || out_free;

    // A register write takes priority, so the input is refused while one is offered.
    assign s_tready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        pixel_next      = pixel_reg;
        open_next       = open_reg;
        prefix_next     = prefix_reg;
        count_next      = count_reg;
        width_next      = width_reg;
        sym_next        = sym_reg;
        last_next       = last_reg;
        hash_next       = hash_reg;
        idx_next        = idx_reg;
        headsave_next   = headsave_reg;
        sweep_next      = sweep_reg;
        sweepfull_next  = sweepfull_reg;
        pend_code_next  = pend_code_reg;
        pend_width_next = pend_width_reg;
        pend_valid_next = pend_valid_reg;
        out_code_next   = out_code_reg;
        out_width_next  = out_width_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        emit_en         = 1'b0;
        emit_code       = prefix_reg[CODE_W-1:0];
        head_we         = 1'b0;
        head_waddr      = sweep_reg;
        head_wdata      = NO_LINK;
        ent_we          = 1'b0;
        ent_wdata       = '{prefix: prefix_reg[CODE_W-1:0], symbol: sym_reg,
                            link: headsave_reg};

        unique case (state_reg)
            ST_IDLE: begin
                if (cfg_valid) begin
                    pixel_next  = cfg_data;
                    open_next   = 1'b0;
                    prefix_next = NO_LINK;
                end else if (s_tvalid) begin
                    sym_next  = s_tdata & sym_mask;
                    last_next = s_tlast;
                    if (!open_reg) begin
                        count_next     = COUNT_W'(clear_code) + COUNT_W'(2);
                        width_next     = eff_bits + WIDTH_W'(1);
                        prefix_next    = NO_LINK;
                        sweep_next     = '0;
                        sweepfull_next = 1'b0;
                        state_next     = ST_SWEEP;
                    end else begin
                        state_next = ST_PROC;
                    end
                end
            end
            ST_SWEEP: begin
                head_we    = 1'b1;
                sweep_next = sweep_reg + HW'(1);
                if (sweep_reg == SWEEP_LAST) begin
                    if (sweepfull_reg) begin
                        prefix_next = LINK_W'(sym_reg);
                        state_next  = ST_LAST;
                    end else begin
                        state_next = ST_START_CLR;
                    end
                end
            end
            ST_START_CLR: begin
                if (can_emit) begin
                    emit_en    = 1'b1;
                    emit_code  = clear_code;
                    open_next  = 1'b1;
                    state_next = ST_PROC;
                end
            end
            ST_PROC: begin
                if (prefix_reg[CODE_W]) begin
                    prefix_next = LINK_W'(sym_reg);
                    state_next  = ST_LAST;
                end else begin
                    hash_next  = hash_now;
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD: begin
                idx_next      = head_rdata;
                headsave_next = head_rdata;
                state_next    = ST_WALK;
            end
            ST_WALK: begin
                if (idx_reg[CODE_W] || (idx_reg >= DICT_LIMIT)) begin
                    state_next = ST_MISS_EMIT;
                end else begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                if ((ent_rdata.prefix == prefix_reg[CODE_W-1:0]) &&
                    (ent_rdata.symbol == sym_reg)) begin
                    prefix_next = idx_reg;
                    state_next  = ST_LAST;
                end else begin
                    idx_next   = ent_rdata.link;
                    state_next = ST_WALK;
                end
            end
            ST_MISS_EMIT: begin
                if (can_emit) begin
                    emit_en = 1'b1;
                    if (count_reg >= DICT_LIMIT) begin
                        state_next = ST_FULL_CLR;
                    end else begin
                        state_next = ST_INSERT;
                    end
                end
            end
            ST_INSERT: begin
                ent_we      = 1'b1;
                head_we     = 1'b1;
                head_waddr  = hash_reg;
                head_wdata  = LINK_W'(count_reg);
                count_next  = count_reg + COUNT_W'(1);
                prefix_next = LINK_W'(sym_reg);
                state_next  = ST_LAST;
            end
            ST_FULL_CLR: begin
                if (can_emit) begin
                    emit_en        = 1'b1;
                    emit_code      = clear_code;
                    count_next     = COUNT_W'(clear_code) + COUNT_W'(2);
                    width_next     = eff_bits + WIDTH_W'(1);
                    sweep_next     = '0;
                    sweepfull_next = 1'b1;
                    state_next     = ST_SWEEP;
                end
            end
            ST_LAST: begin
                state_next = last_reg ? ST_FLUSH : ST_DONE;
            end
            ST_FLUSH: begin
                if (can_emit) begin
                    emit_en    = 1'b1;
                    state_next = ST_END;
                end
            end
            ST_END: begin
                if (can_emit) begin
                    emit_en     = 1'b1;
                    emit_code   = clear_code + CODE_W'(1);
                    open_next   = 1'b0;
                    prefix_next = NO_LINK;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_code_next   = pend_code_reg;
                    out_width_next  = pend_width_reg;
                    out_last_next   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A new code pushes the pending one out; the full-table path sets the
        // width back afterwards, so its restart value wins.
        if (emit_en) begin
            if (pend_valid_reg) begin
                out_code_next  = pend_code_reg;
                out_width_next = pend_width_reg;
                out_last_next  = 1'b0;
                out_valid_next = 1'b1;
            end
            pend_code_next  = emit_code;
            pend_width_next = emit_width;
            pend_valid_next = 1'b1;
            if (state_reg != ST_FULL_CLR) begin
                width_next = emit_width;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pixel_reg      <= PIX_RESET;
            open_reg       <= 1'b0;
            prefix_reg     <= NO_LINK;
            count_reg      <= COUNT_W'(258);
            width_reg      <= WIDTH_W'(9);
            sweepfull_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pixel_reg      <= pixel_next;
            open_reg       <= open_next;
            prefix_reg     <= prefix_next;
            count_reg      <= count_next;
            width_reg      <= width_next;
            sweepfull_reg  <= sweepfull_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sym_reg        <= sym_next;
        last_reg       <= last_next;
        hash_reg       <= hash_next;
        idx_reg        <= idx_next;
        headsave_reg   <= headsave_next;
        sweep_reg      <= sweep_next;
        pend_code_reg  <= pend_code_next;
        pend_width_reg <= pend_width_next;
        out_code_reg   <= out_code_next;
        out_width_reg  <= out_width_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_width_reg, out_code_reg};
    assign m_tlast  = out_last_reg;

    // No code may be left pending once the block is back waiting for input.
    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !pend_valid_reg)
        else $error("code left pending at end of item");

    // The next free code never passes the dictionary size.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DICT_LIMIT)
        else $error("entry count beyond dictionary");

    // Code width stays within three to twelve bits.
    a_width_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (width_reg >= WIDTH_W'(3)) && (width_reg <= MAX_WIDTH))
        else $error("code width out of range");

    // An entry is only compared when the walk stands on a real entry.
    a_cmp_index: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CMP |-> (!idx_reg[CODE_W] && (idx_reg < DICT_LIMIT)))
        else $error("chain walk read outside the dictionary");

endmodule

FILE: tb/sv/lzw_variable_width_encoder_core_tb.sv
module lzw_variable_width_encoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lzwve_pkg::*;

    localparam int DICT_SIZE   = 4096;
    localparam int BUCKETS     = 4096;
    localparam int CYCLE_LIMIT = 3000000;
    // An item that causes no code still walks its hash chain; this covers it.
    localparam int SETTLE_CYCLES = 64;

    // One emitted code as it leaves the m_ channel.
    typedef struct {
        logic [CODE_W-1:0]  code;
        logic [WIDTH_W-1:0] width;
        logic               last;
    } code_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [PIX_W-1:0] cfg_data = '0;

    lzw_variable_width_encoder_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // The clock runs with a 12 ns period.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the dictionary and its hash chains.
    // ------------------------------------------------------------------
    logic [CODE_W-1:0]  dict_prefix [DICT_SIZE];
    logic [SYM_W-1:0]   dict_symbol [DICT_SIZE];
    logic [LINK_W-1:0]  dict_link   [DICT_SIZE];
    logic [LINK_W-1:0]  bucket_first[BUCKETS];
    int unsigned        free_code;
    int unsigned        code_width_now;
    logic [LINK_W-1:0]  run_prefix;
    logic               stream_active;
    logic [PIX_W-1:0]   pixel_reg;

    code_t expected_codes[$];

    int  failures      = 0;
    int  items_sent    = 0;
    int  codes_checked = 0;
    int  cycle_count   = 0;
    int  drain_stall   = 0;

    // The register is clamped to the range the encoder supports.
    function automatic int unsigned symbol_bits();
        if (pixel_reg < PIX_MIN) return PIX_MIN;
        if (pixel_reg > PIX_MAX) return PIX_MAX;
        return pixel_reg;
    endfunction

    function automatic void empty_dictionary();
        for (int i = 0; i < BUCKETS; i++) bucket_first[i] = NO_LINK;
        free_code      = (1 << symbol_bits()) + 2;
        code_width_now = symbol_bits() + 1;
    endfunction

    function automatic int unsigned bucket_of(logic [LINK_W-1:0] pre, int unsigned sym);
        return ((int'(pre[CODE_W-1:0]) * 31) + (sym & 8'hFF)) % BUCKETS;
    endfunction

    // Search the chain for (pre, sym); returns the entry or NO_LINK.
    function automatic logic [LINK_W-1:0] find_pair(logic [LINK_W-1:0] pre, int unsigned sym);
        logic [LINK_W-1:0] idx;
        int                steps;
        idx   = bucket_first[bucket_of(pre, sym)];
        steps = 0;
        while (!idx[12] && steps < DICT_SIZE) begin
            if (dict_prefix[idx] == pre[CODE_W-1:0] && dict_symbol[idx] == sym[SYM_W-1:0])
                return idx;
            idx = dict_link[idx];
            steps++;
        end
        return NO_LINK;
    endfunction

    // The width grows just before a code goes out, when the entry count has
    // outrun the current width.
    function automatic void push_code(ref code_t step_codes[$], input int unsigned value);
        code_t c;
        if (step_codes.size() >= 4) return;
        if (free_code > (1 << code_width_now) && code_width_now < MAX_WIDTH)
            code_width_now++;
        c.code  = value[CODE_W-1:0];
        c.width = code_width_now[WIDTH_W-1:0];
        c.last  = 1'b0;
        step_codes.push_back(c);
    endfunction

    function automatic void reset_encoder_model(logic [PIX_W-1:0] bits);
        pixel_reg = bits;
        empty_dictionary();
        run_prefix    = NO_LINK;
        stream_active = 1'b0;
    endfunction

    // Works out the codes that one accepted byte causes and queues them.
    function automatic void encode_byte(logic [7:0] data, logic last);
        code_t             step_codes[$];
        int unsigned       clear_code;
        int unsigned       sym;
        int unsigned       bucket;
        logic [LINK_W-1:0] hit;
        clear_code = 1 << symbol_bits();
        sym        = data & (clear_code - 1);
        if (!stream_active) begin
            empty_dictionary();
            run_prefix = NO_LINK;
            push_code(step_codes, clear_code);
            stream_active = 1'b1;
        end
        if (run_prefix[12]) begin
            run_prefix = LINK_W'(sym);
        end else begin
            hit = find_pair(run_prefix, sym);
            if (!hit[12]) begin
                run_prefix = hit;
            end else begin
                push_code(step_codes, run_prefix);
                bucket = bucket_of(run_prefix, sym);
                if (free_code >= DICT_SIZE) begin
                    push_code(step_codes, clear_code);
                    empty_dictionary();
                end else begin
                    dict_prefix[free_code] = run_prefix[CODE_W-1:0];
                    dict_symbol[free_code] = sym[SYM_W-1:0];
                    dict_link[free_code]   = bucket_first[bucket];
                    bucket_first[bucket]   = free_code[LINK_W-1:0];
                    free_code++;
                end
                run_prefix = LINK_W'(sym);
            end
        end
        if (last) begin
            push_code(step_codes, run_prefix);
            push_code(step_codes, clear_code + 1);
            stream_active = 1'b0;
            run_prefix    = NO_LINK;
        end
        if (step_codes.size() > 0) step_codes[step_codes.size()-1].last = 1'b1;
        foreach (step_codes[i]) expected_codes.push_back(step_codes[i]);
    endfunction

    // ------------------------------------------------------------------
    // Result checking: every code transaction on m_ is compared with the
    // oldest expectation, field by field.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_codes.size() == 0) begin
                $error("unexpected code transaction: code %0d width %0d last %0b",
                       m_tdata[11:0], m_tdata[15:12], m_tlast);
                failures++;
            end else begin
                code_t want;
                want = expected_codes.pop_front();
                if (m_tdata[11:0] !== want.code) begin
                    $error("code: expected %0d, got %0d", want.code, m_tdata[11:0]);
                    failures++;
                end
                if (m_tdata[15:12] !== want.width) begin
                    $error("code_width: expected %0d, got %0d", want.width, m_tdata[15:12]);
                    failures++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_code: expected %0b, got %0b", want.last, m_tlast);
                    failures++;
                end
                codes_checked++;
            end
        end
    end

    // Back-pressure on the result side: mostly ready, short stalls now and
    // then, and the odd long one.
    always @(posedge aclk) begin
        int roll;
        roll = $urandom_range(0, 99);
        if (drain_stall > 0) begin
            m_tready    <= 1'b0;
            drain_stall <= drain_stall - 1;
        end else begin
            m_tready <= 1'b1;
            if (roll < 15) drain_stall <= $urandom_range(1, 3);
            else if (roll < 18) drain_stall <= $urandom_range(10, 40);
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Sends one byte; the prediction is made at the accepting edge. Valid is
    // only lowered when a gap follows, so it never toggles within one step.
    task automatic send_byte(logic [7:0] data, logic last);
        int roll;
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        encode_byte(data, last);
        items_sent++;
        roll = $urandom_range(0, 99);
        if (roll < 55) gap = 0;
        else if (roll < 90) gap = $urandom_range(1, 3);
        else gap = $urandom_range(8, 30);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // The input is withdrawn first, so the last byte is not offered again.
    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        while (expected_codes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // The register is only written with the encoder idle; the write drops
    // any open stream and sets the new symbol width.
    task automatic write_pixel_bits(logic [PIX_W-1:0] bits);
        wait_until_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= bits;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        reset_encoder_model(bits);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // A stream of random bytes; a narrow alphabet makes prefixes repeat so
    // that the chains are walked and hits extend the prefix.
    task automatic send_stream(int len, int alphabet);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(0, alphabet - 1) | ($urandom_range(0, 1) ? 8'h00 :
                      ($urandom_range(0, 255) & ~((1 << symbol_bits()) - 1)))),
                      i == len - 1);
    endtask

    // Reset state: eight-bit symbols, extremes of the byte, and a repeated
    // byte so that a pair is found on its second appearance.
    task automatic test_reset_defaults();
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        // A stream of a single byte gives clear, the byte and the end code.
        send_byte(8'hA5, 1'b1);
    endtask

    // Register extremes and out-of-range values, with wide bytes masked.
    task automatic test_pixel_extremes();
        write_pixel_bits(4'd0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'hFC, 1'b0);
        send_byte(8'h03, 1'b1);
        write_pixel_bits(4'd15);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b1);
        write_pixel_bits(4'd1);
        send_byte(8'h55, 1'b1);
        write_pixel_bits(4'd9);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        write_pixel_bits(PIX_MIN);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h01, 1'b1);
    endtask

    // Random phases over many register settings and stream lengths.
    task automatic test_random_streams();
        logic [PIX_W-1:0] bits;
        int               remaining;
        int               len;
        for (int phase = 0; phase < 7; phase++) begin
            bits = (phase == 0) ? PIX_MAX : (phase == 1) ? PIX_MIN :
                   PIX_W'($urandom_range(0, 15));
            write_pixel_bits(bits);
            remaining = 22;
            while (remaining > 0) begin
                len = $urandom_range(1, 12);
                if (len > remaining) len = remaining;
                send_stream(len, $urandom_range(0, 1) ? 2 : (1 << symbol_bits()));
                remaining -= len;
            end
        end
    endtask

    initial begin
        reset_encoder_model(PIX_RESET);
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_pixel_extremes();
        test_random_streams();

        wait_until_drained();

        $display("Sent %0d bytes and checked %0d codes over streams at several symbol widths,",
                 items_sent, codes_checked);
        $display("with out-of-range register values, masked bytes and output stalls.");
        if (failures == 0 && expected_codes.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/lzwve_pkg.sv
sv/lzwve_dict.sv
sv/lzw_variable_width_encoder_core.sv
tb/sv/lzw_variable_width_encoder_core_tb.sv
